/* sv/fjtg_pkg.sv */
// ============================================================================
// fjtg_pkg
// Shared constants, coefficient ROM and control types of the joint
// trajectory generator.
// ============================================================================
`default_nettype none

package fjtg_pkg;

  // Quarter-wave sine table and harmonic count
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int HARMONICS        = 6;
  localparam int HARM_W           = $clog2(HARMONICS + 1);

  // Datapath widths
  localparam int PH_W     = 32;
  localparam int ACC_W    = 32;
  localparam int COEF_W   = 16;
  localparam int SINE_W   = 17;
  localparam int MRAD_W   = 16;
  localparam int SER_W    = 2;
  localparam int AMP_W    = 16;

  // Coefficient ROM, degrees Q8, harmonics above six are zero
  localparam int ROM_TERMS = 9;
  localparam int ROM_IDX_W = $clog2(ROM_TERMS);

  typedef logic signed [COEF_W-1:0] coef_rom_t [0:ROM_TERMS-1];

  localparam coef_rom_t HIP_COS  = '{16'sd10417, 16'sd5944, -16'sd1149, 16'sd102, 16'sd180,
                                     16'sd276, -16'sd70, 16'sd0, 16'sd0};
  localparam coef_rom_t HIP_SIN  = '{16'sd0, -16'sd2214, 16'sd855, 16'sd356, 16'sd205,
                                     16'sd88, 16'sd17, 16'sd0, 16'sd0};
  localparam coef_rom_t KNEE_COS = '{16'sd6579, -16'sd980, -16'sd2186, 16'sd489, 16'sd279,
                                     16'sd525, -16'sd79, 16'sd0, 16'sd0};
  localparam coef_rom_t KNEE_SIN = '{16'sd0, -16'sd4936, 16'sd4590, 16'sd965, 16'sd384,
                                     16'sd148, -16'sd230, 16'sd0, 16'sd0};

  // Series numbering: both hips share coefficients, the knee has its own
  localparam logic [SER_W-1:0] SER_HIP1 = 2'd0;
  localparam logic [SER_W-1:0] SER_HIP2 = 2'd1;
  localparam logic [SER_W-1:0] SER_KNEE = 2'd2;

  typedef enum logic [1:0] {
    OP_TERM,
    OP_GAIN_LO,
    OP_GAIN_HI
  } op_kind_t;

  typedef struct packed {
    logic                     valid;
    op_kind_t                 kind;
    logic [SER_W-1:0]         series;
    logic signed [COEF_W-1:0] coef;
  } mac_op_t;

  typedef struct packed {
    logic                    init;
    logic signed [AMP_W-1:0] amp_shift;
    mac_op_t                 op;
  } mac_ctl_t;

  typedef struct packed {
    logic                   done;
    logic [2:0]             sat;
    logic [2:0][MRAD_W-1:0] mrad;
  } mac_res_t;

  function automatic logic signed [COEF_W-1:0] coef_lookup(
    input logic                 knee,
    input logic                 sin_sel,
    input logic [ROM_IDX_W-1:0] k
  );
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (k < ROM_IDX_W'(ROM_TERMS)) begin
      case ({knee, sin_sel})
        2'b00:   c = HIP_COS[k];
        2'b01:   c = HIP_SIN[k];
        2'b10:   c = KNEE_COS[k];
        2'b11:   c = KNEE_SIN[k];
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* sv/fjtg_sincos.sv */
// ============================================================================
// fjtg_sincos
// Quarter-wave sine lookup: phase in, registered signed Q15 sine out.
// ============================================================================
`default_nettype none

module fjtg_sincos (
  input  wire logic                             clk,
  input  wire logic [fjtg_pkg::PH_W-1:0]        phase,
  output logic signed [fjtg_pkg::SINE_W-1:0]    sine
);
  import fjtg_pkg::*;

  localparam int IDX_PROD_W = 30 + SINE_AW;

  typedef logic [14:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  // Entry i is sin(pi/2 * i / depth) from a Taylor series to x^13 in Q30,
  // rounded half up to Q15.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] q;
    logic signed [63:0] sum;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = (64'd1686629713 * 64'(i)) / SINE_TABLE_DEPTH;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 6; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        case (n)
          1:       term = term / 6;
          2:       term = term / 20;
          3:       term = term / 42;
          4:       term = term / 72;
          5:       term = term / 110;
          default: term = term / 156;
        endcase
        if (n % 2 == 1) sum = sum - signed'(term);
        else            sum = sum + signed'(term);
      end
      if (sum < 0) sum = '0;
      q = (unsigned'(sum) + 64'd16384) >> 15;
      if (q > 64'd32767) q = 64'd32767;
      tab[i] = q[14:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  logic [IDX_PROD_W-1:0] idx_prod;
  logic [SINE_AW-1:0]    idx;
  logic [SINE_AW-1:0]    addr;
  logic [SINE_AW-1:0]    addr_r;
  logic                  neg_r;
  logic                  neg2_r;
  logic [14:0]           rom_r;

  // Index is the low 30 phase bits scaled to the table depth.
  assign idx_prod = IDX_PROD_W'(phase[29:0]) * IDX_PROD_W'(SINE_TABLE_DEPTH);
  assign idx      = idx_prod[IDX_PROD_W-1:30];
  assign addr     = phase[30] ? (SINE_AW'(SINE_TABLE_DEPTH) - idx) : idx;

  always_ff @(posedge clk) begin
    addr_r <= addr;
    neg_r  <= phase[31];
    rom_r  <= SINE_TAB[addr_r];
    neg2_r <= neg_r;
  end

  assign sine = neg2_r ? -signed'({2'b00, rom_r}) : signed'({2'b00, rom_r});

endmodule

`default_nettype wire

/* sv/fjtg_mac.sv */
// ============================================================================
// fjtg_mac
// Shared multiplier with series accumulators, joint gain scaling,
// truncation toward zero and 16-bit saturation.
// ============================================================================
`default_nettype none

module fjtg_mac (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire fjtg_pkg::mac_ctl_t                 ctl,
  input  wire logic signed [fjtg_pkg::SINE_W-1:0] sine,
  output fjtg_pkg::mac_res_t                      res
);
  import fjtg_pkg::*;

  localparam int GAIN_W   = 24;
  localparam int PROD_W   = SINE_W + GAIN_W;
  localparam int FULL_W   = 57;
  localparam int SCALE_SH = 39;
  localparam int Q_W      = FULL_W - SCALE_SH;
  localparam int HALF_W   = ACC_W / 2;

  // Joint gains: gain * pi / 180 * 1000 in Q16
  localparam logic signed [GAIN_W-1:0] G_HIP1 = 24'sd1429774;
  localparam logic signed [GAIN_W-1:0] G_HIP2 = -24'sd2287638;
  localparam logic signed [GAIN_W-1:0] G_KNEE = -24'sd8006733;

  localparam logic signed [FULL_W-1:0] TRUNC_BIAS =
    {{(FULL_W - SCALE_SH){1'b0}}, {SCALE_SH{1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
  localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);

  mac_op_t tag1_r, tag2_r, tag3_r;

  logic signed [ACC_W-1:0]  acc_r [3];
  logic signed [ACC_W-1:0]  acc_sel;
  logic signed [GAIN_W-1:0] gain_sel;
  logic signed [SINE_W-1:0] mul_a;
  logic signed [GAIN_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] lo_r;
  logic signed [FULL_W-1:0] full_r;
  logic                     full_vld_r;
  logic [SER_W-1:0]         full_ser_r;
  logic signed [FULL_W-1:0] biased;
  logic signed [Q_W-1:0]    q;
  logic [MRAD_W-1:0]        mrad_r [3];
  logic [2:0]               sat_r;
  logic                     done_r;
  logic signed [AMP_W:0]    hip_base;
  logic signed [AMP_W:0]    knee_base;

  always_comb begin
    case (tag2_r.series)
      SER_HIP1: begin acc_sel = acc_r[0]; gain_sel = G_HIP1; end
      SER_HIP2: begin acc_sel = acc_r[1]; gain_sel = G_HIP2; end
      SER_KNEE: begin acc_sel = acc_r[2]; gain_sel = G_KNEE; end
      default:  begin acc_sel = '0;       gain_sel = '0;     end
    endcase
  end

  // The wide sum times the gain is split into a low half (unsigned) and a
  // high half (signed) that pass the same multiplier one after the other.
  always_comb begin
    case (tag2_r.kind)
      OP_GAIN_LO: begin
        mul_a = signed'({1'b0, acc_sel[HALF_W-1:0]});
        mul_b = gain_sel;
      end
      OP_GAIN_HI: begin
        mul_a = signed'({acc_sel[ACC_W-1], acc_sel[ACC_W-1:HALF_W]});
        mul_b = gain_sel;
      end
      default: begin
        mul_a = sine;
        mul_b = GAIN_W'(tag2_r.coef);
      end
    endcase
  end

  // Truncation toward zero: negative values are biased before the shift.
  assign biased = full_r + (full_r[FULL_W-1] ? TRUNC_BIAS : '0);
  assign q      = biased[FULL_W-1:SCALE_SH];

  assign hip_base  = {HIP_COS[0][COEF_W-1], HIP_COS[0]}  - {ctl.amp_shift[AMP_W-1], ctl.amp_shift};
  assign knee_base = {KNEE_COS[0][COEF_W-1], KNEE_COS[0]} -
                     {ctl.amp_shift[AMP_W-1], ctl.amp_shift};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.valid <= 1'b0;
      tag2_r.valid <= 1'b0;
      tag3_r.valid <= 1'b0;
      full_vld_r   <= 1'b0;
      done_r       <= 1'b0;
      sat_r        <= '0;
    end else begin
      tag1_r     <= ctl.op;
      tag2_r     <= tag1_r;
      tag3_r     <= tag2_r;
      prod_r     <= mul_a * mul_b;
      full_vld_r <= !ctl.init && tag3_r.valid && (tag3_r.kind == OP_GAIN_HI);
      done_r     <= full_vld_r && (full_ser_r == SER_KNEE);

      if (ctl.init) begin
        acc_r[0] <= {hip_base, 15'd0};
        acc_r[1] <= {hip_base, 15'd0};
        acc_r[2] <= {knee_base, 15'd0};
        sat_r    <= '0;
      end else if (tag3_r.valid) begin
        case (tag3_r.kind)
          OP_TERM: begin
            acc_r[tag3_r.series] <= acc_r[tag3_r.series] + signed'(prod_r[ACC_W-1:0]);
          end
          OP_GAIN_LO: begin
            lo_r <= prod_r;
          end
          OP_GAIN_HI: begin
            full_r     <= (FULL_W'(prod_r) <<< HALF_W) + FULL_W'(lo_r);
            full_ser_r <= tag3_r.series;
          end
          default: ;
        endcase
      end

      if (full_vld_r) begin
        if (q > Q_MAX) begin
          mrad_r[full_ser_r] <= MRAD_W'(Q_MAX);
          sat_r[full_ser_r]  <= 1'b1;
        end else if (q < Q_MIN) begin
          mrad_r[full_ser_r] <= MRAD_W'(Q_MIN);
          sat_r[full_ser_r]  <= 1'b1;
        end else begin
          mrad_r[full_ser_r] <= q[MRAD_W-1:0];
        end
      end
    end
  end

  assign res.done    = done_r;
  assign res.sat     = sat_r;
  assign res.mrad[0] = mrad_r[0];
  assign res.mrad[1] = mrad_r[1];
  assign res.mrad[2] = mrad_r[2];

endmodule

`default_nettype wire

/* sv/fourier_joint_trajectory_generator.sv */
// ============================================================================
// fourier_joint_trajectory_generator
// Three-joint setpoint generator from six-harmonic Fourier series, with hold,
// run and done stages, one shared multiplier under a small sequencer.
// ============================================================================
//
//  Channel  Direction  Payload
//  in_      slave      in_tdata[0] restart
//  out_     master     out_tdata: hip_first, hip_second, knee; out_tuser: stage, saturated
//  cfg_     write      cfg_index 0..4, cfg_wdata up to 32 bits
//
//  In a hold or run tick, 36 sine terms and 6 gain partial products pass one
//  at a time through the shared multiplier, followed by the pipeline drain.
//  A tick in the done stage skips the multiplier and goes straight to output.
//  in_tready is high only while the sequencer is idle; a finished result
//  waits in the output register, and the next request is taken meanwhile.
//  Synchronous active-low reset clears the stage, tick count and phase.
//
`default_nettype none

module fourier_joint_trajectory_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [0] restart
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,   // [15:0] hip_first_mrad, [31:16] hip_second_mrad,
                                        // [47:32] knee_mrad
  output logic [2:0]       out_tuser,   // [1:0] stage, [2] saturated
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import fjtg_pkg::*;

  localparam logic [2:0] CFG_PHASE_STEP  = 3'd0;
  localparam logic [2:0] CFG_HIP2_OFFSET = 3'd1;
  localparam logic [2:0] CFG_HOLD_TICKS  = 3'd2;
  localparam logic [2:0] CFG_RUN_TICKS   = 3'd3;
  localparam logic [2:0] CFG_AMP_SHIFT   = 3'd4;

  localparam logic [1:0] STAGE_HOLD = 2'd0;
  localparam logic [1:0] STAGE_RUN  = 2'd1;
  localparam logic [1:0] STAGE_DONE = 2'd2;

  localparam logic [PH_W-1:0] QUARTER_TURN = 32'h4000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TERMS,
    ST_GAIN,
    ST_WAIT,
    ST_OUT
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [PH_W-1:0]         phase_step_r;
  logic [PH_W-1:0]         hip2_offset_r;
  logic [15:0]             hold_ticks_r;
  logic [15:0]             run_ticks_r;
  logic signed [AMP_W-1:0] amp_shift_r;

  // Trajectory state
  logic [1:0]      stage_r;
  logic [15:0]     tick_r;
  logic [PH_W-1:0] phase_r;

  // Sequencer
  logic [1:0]       cur_stage_r;
  logic [PH_W-1:0]  p_r;
  logic [PH_W-1:0]  ps_r;
  logic [PH_W-1:0]  hk_r;
  logic [SER_W-1:0] ser_r;
  logic [HARM_W-1:0] harm_r;
  logic             half_r;

  logic        out_tvalid_r;
  logic [47:0] out_tdata_r;
  logic [2:0]  out_tuser_r;

  logic            in_accept;
  logic [1:0]      st_hold;
  logic [15:0]     tc_hold;
  logic [PH_W-1:0] ph_hold;
  logic [1:0]      stage_nxt;
  logic [15:0]     tick_nxt;
  logic [PH_W-1:0] phase_nxt;
  logic [PH_W-1:0] base_nxt;
  logic            tick_done;
  logic [PH_W-1:0] series_base;
  logic [PH_W-1:0] lookup_phase;

  mac_ctl_t                 mac_ctl;
  mac_res_t                 mac_res;
  logic signed [SINE_W-1:0] sine;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r  <= 32'd4443175;
      hip2_offset_r <= 32'h8000_0000;
      hold_ticks_r  <= 16'd501;
      run_ticks_r   <= 16'd4834;
      amp_shift_r   <= 16'sd5888;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PHASE_STEP:  phase_step_r  <= cfg_wdata;
        CFG_HIP2_OFFSET: hip2_offset_r <= cfg_wdata;
        CFG_HOLD_TICKS:  hold_ticks_r  <= cfg_wdata[15:0];
        CFG_RUN_TICKS:   run_ticks_r   <= cfg_wdata[15:0];
        CFG_AMP_SHIFT:   amp_shift_r   <= signed'(cfg_wdata[15:0]);
        default: ;
      endcase
    end
  end

  // Stage transitions taken at the start of each tick.
  always_comb begin
    st_hold = in_tdata[0] ? STAGE_HOLD : stage_r;
    tc_hold = in_tdata[0] ? 16'd0 : tick_r;
    ph_hold = in_tdata[0] ? '0 : phase_r;
    if (st_hold == STAGE_HOLD && tc_hold >= hold_ticks_r) begin
      st_hold = STAGE_RUN;
      tc_hold = 16'd0;
      ph_hold = '0;
    end
    stage_nxt = st_hold;
    if (st_hold == STAGE_RUN && tc_hold >= run_ticks_r) stage_nxt = STAGE_DONE;
    // The unused stage code counts as done.
    tick_done = (stage_nxt != STAGE_HOLD) && (stage_nxt != STAGE_RUN);
    tick_nxt  = tick_done ? tc_hold : tc_hold + 16'd1;
    phase_nxt = (stage_nxt == STAGE_RUN) ? ph_hold + phase_step_r : ph_hold;
    base_nxt  = (stage_nxt == STAGE_HOLD) ? '0 : ph_hold;
  end

  assign series_base  = (ser_r == SER_HIP1) ? p_r - hip2_offset_r : p_r;
  assign lookup_phase = half_r ? hk_r : hk_r + QUARTER_TURN;

  always_comb begin
    mac_ctl.init         = in_accept && !tick_done;
    mac_ctl.amp_shift    = amp_shift_r;
    mac_ctl.op.valid     = (state_r == ST_TERMS) || (state_r == ST_GAIN);
    mac_ctl.op.series    = ser_r;
    mac_ctl.op.coef      = coef_lookup(ser_r == SER_KNEE, half_r, ROM_IDX_W'(harm_r));
    if (state_r == ST_GAIN) mac_ctl.op.kind = half_r ? OP_GAIN_HI : OP_GAIN_LO;
    else                    mac_ctl.op.kind = OP_TERM;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      stage_r      <= STAGE_HOLD;
      tick_r       <= '0;
      phase_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && state_r != ST_OUT) out_tvalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            stage_r     <= stage_nxt;
            tick_r      <= tick_nxt;
            phase_r     <= tick_done ? ph_hold : phase_nxt;
            cur_stage_r <= tick_done ? STAGE_DONE : stage_nxt;
            p_r         <= base_nxt;
            ps_r        <= base_nxt;
            hk_r        <= base_nxt;
            ser_r       <= SER_HIP1;
            harm_r      <= HARM_W'(1);
            half_r      <= 1'b0;
            state_r     <= tick_done ? ST_OUT : ST_TERMS;
          end
        end
        ST_TERMS: begin
          // Cosine then sine of each harmonic; the harmonic phase grows by
          // the series base phase from one harmonic to the next.
          half_r <= !half_r;
          if (half_r) begin
            if (harm_r == HARM_W'(HARMONICS)) begin
              harm_r <= HARM_W'(1);
              if (ser_r == SER_KNEE) begin
                ser_r   <= SER_HIP1;
                state_r <= ST_GAIN;
              end else begin
                ser_r <= ser_r + 2'd1;
                ps_r  <= series_base;
                hk_r  <= series_base;
              end
            end else begin
              harm_r <= harm_r + HARM_W'(1);
              hk_r   <= hk_r + ps_r;
            end
          end
        end
        ST_GAIN: begin
          half_r <= !half_r;
          if (half_r) begin
            if (ser_r == SER_KNEE) state_r <= ST_WAIT;
            else                   ser_r   <= ser_r + 2'd1;
          end
        end
        ST_WAIT: begin
          if (mac_res.done) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            if (cur_stage_r == STAGE_DONE) begin
              out_tdata_r <= '0;
              out_tuser_r <= {1'b0, STAGE_DONE};
            end else begin
              out_tdata_r <= {mac_res.mrad[2], mac_res.mrad[1], mac_res.mrad[0]};
              out_tuser_r <= {|mac_res.sat, cur_stage_r};
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  fjtg_sincos u_sincos (
    .clk   (clk),
    .phase (lookup_phase),
    .sine  (sine)
  );

  fjtg_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .sine  (sine),
    .res   (mac_res)
  );

endmodule

`default_nettype wire
